FILE: design/int8_kronecker_product_core_assert.svh
// assertion macros for the kronecker product core
// expects clk_i and rst_ni in the scope of use
`ifndef INT8_KRONECKER_PRODUCT_CORE_ASSERT_SVH
`define INT8_KRONECKER_PRODUCT_CORE_ASSERT_SVH

// same-cycle implication
`define KP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kronecker core assertion failed");

// next-cycle implication
`define KP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kronecker core assertion failed");

`endif

FILE: design/int8kp_pkg.sv
// shared types and constants for the kronecker product core
// no dependencies
package int8kp_pkg;

  localparam int LEFT_CAPACITY_DEF  = 8;
  localparam int RIGHT_CAPACITY_DEF = 8;
  localparam int MAX_PRODUCTS       = 64;
  localparam int QUEUE_DEPTH        = 4;

  localparam int DIM_W     = 4;
  localparam int IDX_W     = 3;
  localparam int VAL_W     = 8;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SIZE_W    = 2 * DIM_W;
  localparam int TOTAL_W   = 2 * SIZE_W;

  localparam logic [REQ_W-1:0] REQ_WR_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WR_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

  typedef enum logic [1:0] {
    CMD_WR_A,
    CMD_WR_B,
    CMD_RUN,
    CMD_ERR
  } cmd_e;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] cols_a;
    logic [DIM_W-1:0] rows_b;
    logic [DIM_W-1:0] cols_b;
  } cfg_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
  } qent_t;

endpackage

FILE: design/int8kp_front.sv
// front end: accepts requests, checks sizes and indexes, emits commands
// depends on int8kp_pkg
module int8kp_front import int8kp_pkg::*; #(
  parameter int LeftCapacity  = LEFT_CAPACITY_DEF,
  parameter int RightCapacity = RIGHT_CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [REQ_W-1:0]              req_type_i,
  input  logic [IDX_W-1:0]              elem_index_i,
  input  logic [VAL_W-1:0]              elem_value_i,
  input  cfg_t                          cfg_i,
  input  logic [$clog2(QUEUE_DEPTH):0]  q_count_i,
  output logic                          busy_o,
  output logic                          push_o,
  output qent_t                         push_data_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH) + 1;
  localparam int CMP_W = 7;
  localparam logic [SIZE_W-1:0]  LCAP_S  = SIZE_W'(LeftCapacity);
  localparam logic [SIZE_W-1:0]  RCAP_S  = SIZE_W'(RightCapacity);
  localparam logic [CMP_W-1:0]   LCAP_I  = CMP_W'(LeftCapacity);
  localparam logic [CMP_W-1:0]   RCAP_I  = CMP_W'(RightCapacity);
  localparam logic [TOTAL_W-1:0] MAXP_T  = TOTAL_W'(MAX_PRODUCTS);
  localparam logic [CNT_W-1:0]   DEPTH_C = CNT_W'(QUEUE_DEPTH);

  logic              accept;
  logic [CNT_W-1:0]  inflight;

  logic              s1_v_q, s1_v_d;
  logic [REQ_W-1:0]  s1_req_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic [VAL_W-1:0]  s1_val_q;

  logic              s2_v_q, s2_v_d;
  logic [REQ_W-1:0]  s2_req_q;
  logic [IDX_W-1:0]  s2_idx_q;
  logic [VAL_W-1:0]  s2_val_q;
  logic [SIZE_W-1:0] sa_q, sb_q;

  logic [TOTAL_W-1:0] total;
  logic [CMP_W-1:0]   idx_ext;

  assign inflight = CNT_W'(s1_v_q) + CNT_W'(s2_v_q) + q_count_i;
  assign busy_o   = (inflight >= DEPTH_C);
  assign accept   = start_i && !busy_o;

  assign s1_v_d = accept;
  assign s2_v_d = s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= req_type_i;
      s1_idx_q <= elem_index_i;
      s1_val_q <= elem_value_i;
    end
    if (s1_v_q) begin
      s2_req_q <= s1_req_q;
      s2_idx_q <= s1_idx_q;
      s2_val_q <= s1_val_q;
      sa_q     <= SIZE_W'(cfg_i.rows_a) * SIZE_W'(cfg_i.cols_a);
      sb_q     <= SIZE_W'(cfg_i.rows_b) * SIZE_W'(cfg_i.cols_b);
    end
  end

  assign total   = TOTAL_W'(sa_q) * TOTAL_W'(sb_q);
  assign idx_ext = CMP_W'(s2_idx_q);

  always_comb begin
    push_o          = 1'b0;
    push_data_o.cmd = CMD_RUN;
    push_data_o.idx = s2_idx_q;
    push_data_o.val = s2_val_q;
    if (s2_v_q) begin
      unique case (s2_req_q)
        REQ_WR_A: begin
          push_o          = (idx_ext < LCAP_I);
          push_data_o.cmd = CMD_WR_A;
        end
        REQ_WR_B: begin
          push_o          = (idx_ext < RCAP_I);
          push_data_o.cmd = CMD_WR_B;
        end
        REQ_RUN: begin
          priority if (sa_q > LCAP_S || sb_q > RCAP_S || total > MAXP_T) begin
            push_o          = 1'b1;
            push_data_o.cmd = CMD_ERR;
          end else if (sa_q == '0 || sb_q == '0) begin
            push_o = 1'b0;
          end else begin
            push_o          = 1'b1;
            push_data_o.cmd = CMD_RUN;
          end
        end
        REQ_NONE: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: design/int8kp_fifo.sv
// command queue between front end and back end
// depends on int8kp_pkg
module int8kp_fifo import int8kp_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  qent_t                         push_data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output qent_t                         head_o,
  output logic [$clog2(QUEUE_DEPTH):0]  count_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  qent_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/int8kp_back.sv
// back end: element stores, product sequencer, multiplier and result register
// depends on int8kp_pkg and int8_kronecker_product_core_assert.svh
`include "int8_kronecker_product_core_assert.svh"
module int8kp_back import int8kp_pkg::*; #(
  parameter int LeftCapacity  = LEFT_CAPACITY_DEF,
  parameter int RightCapacity = RIGHT_CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     q_valid_i,
  input  qent_t                    q_head_i,
  output logic                     pop_o,
  output logic                     result_valid_o,
  output logic signed [VAL_W-1:0]  product_o,
  output logic                     last_product_o,
  output logic                     size_error_o
);

  localparam int AW_A = (LeftCapacity > 1) ? $clog2(LeftCapacity) : 1;
  localparam int AW_B = (RightCapacity > 1) ? $clog2(RightCapacity) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [VAL_W-1:0] left_mem  [LeftCapacity];
  logic [VAL_W-1:0] right_mem [RightCapacity];

  logic state_q, state_d;
  logic [DIM_W-1:0] ca_q, ca_d, cb_q, cb_d, ra_q, ra_d, rb_q, rb_d;
  logic [AW_A-1:0]  a_base_q, a_base_d, a_addr, a_waddr;
  logic [AW_B-1:0]  b_base_q, b_base_d, b_addr, b_waddr;
  logic [IDX_W+AW_A-1:0] a_wext;
  logic [IDX_W+AW_B-1:0] b_wext;

  logic issue, last_issue, err_inject, wr_a, wr_b;
  logic ca_last, cb_last, ra_last, rb_last;

  logic             s_v_q, s_last_q, s_err_q;
  logic [VAL_W-1:0] a_rd_q, b_rd_q;
  logic signed [2*VAL_W-1:0] mult;

  logic                    out_v_q, out_last_q, out_err_q;
  logic signed [VAL_W-1:0] out_prod_q;

  assign ca_last = (ca_q == cfg_i.cols_a - 1'b1);
  assign cb_last = (cb_q == cfg_i.cols_b - 1'b1);
  assign ra_last = (ra_q == cfg_i.rows_a - 1'b1);
  assign rb_last = (rb_q == cfg_i.rows_b - 1'b1);

  assign issue      = (state_q == ST_RUN);
  assign last_issue = ca_last && cb_last && ra_last && rb_last;
  assign pop_o      = (state_q == ST_IDLE) && q_valid_i;
  assign err_inject = pop_o && (q_head_i.cmd == CMD_ERR);
  assign wr_a       = pop_o && (q_head_i.cmd == CMD_WR_A);
  assign wr_b       = pop_o && (q_head_i.cmd == CMD_WR_B);

  assign a_addr  = a_base_q + AW_A'(ra_q);
  assign b_addr  = b_base_q + AW_B'(rb_q);
  assign a_wext  = {AW_A'(0), q_head_i.idx};
  assign b_wext  = {AW_B'(0), q_head_i.idx};
  assign a_waddr = a_wext[AW_A-1:0];
  assign b_waddr = b_wext[AW_B-1:0];

  always_comb begin
    state_d  = state_q;
    ca_d     = ca_q;
    cb_d     = cb_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    a_base_d = a_base_q;
    b_base_d = b_base_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          unique case (q_head_i.cmd)
            CMD_RUN: begin
              state_d  = ST_RUN;
              ca_d     = '0;
              cb_d     = '0;
              ra_d     = '0;
              rb_d     = '0;
              a_base_d = '0;
              b_base_d = '0;
            end
            CMD_WR_A, CMD_WR_B, CMD_ERR: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (!rb_last) begin
          rb_d = rb_q + 1'b1;
        end else begin
          rb_d = '0;
          if (!ra_last) begin
            ra_d = ra_q + 1'b1;
          end else begin
            ra_d = '0;
            if (!cb_last) begin
              cb_d     = cb_q + 1'b1;
              b_base_d = AW_B'({{DIM_W{1'b0}}, b_base_q} + (AW_B + DIM_W)'(cfg_i.rows_b));
            end else begin
              cb_d     = '0;
              b_base_d = '0;
              if (!ca_last) begin
                ca_d     = ca_q + 1'b1;
                a_base_d = AW_A'({{DIM_W{1'b0}}, a_base_q} + (AW_A + DIM_W)'(cfg_i.rows_a));
              end else begin
                state_d = ST_IDLE;
              end
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s_v_q      <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      s_v_q      <= issue || err_inject;
      out_v_q    <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q     <= ca_d;
    cb_q     <= cb_d;
    ra_q     <= ra_d;
    rb_q     <= rb_d;
    a_base_q <= a_base_d;
    b_base_q <= b_base_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      left_mem[a_waddr] <= q_head_i.val;
    end
    if (wr_b) begin
      right_mem[b_waddr] <= q_head_i.val;
    end
    if (issue) begin
      a_rd_q <= left_mem[a_addr];
      b_rd_q <= right_mem[b_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    s_last_q <= issue ? last_issue : 1'b1;
    s_err_q  <= err_inject;
  end

  assign mult = $signed({{VAL_W{a_rd_q[VAL_W-1]}}, a_rd_q}) *
                $signed({{VAL_W{b_rd_q[VAL_W-1]}}, b_rd_q});

  always_ff @(posedge clk_i) begin
    out_prod_q <= s_err_q ? '0 : mult[VAL_W-1:0];
    out_last_q <= s_last_q;
    out_err_q  <= s_err_q;
  end

  assign result_valid_o = out_v_q;
  assign product_o      = out_prod_q;
  assign last_product_o = out_last_q;
  assign size_error_o   = out_err_q;

  `KP_ASSERT_IMPL(a_err_is_single, result_valid_o && size_error_o, last_product_o && product_o == '0)
  `KP_ASSERT_IMPL(a_no_pop_in_run, state_q == ST_RUN, !pop_o)
  `KP_ASSERT_NEXT(a_run_ends, issue && last_issue, state_q == ST_IDLE && s_v_q && s_last_q)

endmodule

FILE: design/int8_kronecker_product_core.sv
// int8 kronecker product core: up to one load per cycle while busy_o is low
// a run emits rows_a*cols_a*rows_b*cols_b products, one per cycle from the sequencer;
// runs pass front end, queue, sequencer, read and result registers; errors skip the sequencer
// the 4-entry command queue sets how far loads and runs can be accepted ahead of the sequencer
// reset clears config to 1x1 matrices and empties the queue; element stores are undefined
// results are strobed for one cycle on result_valid_o; the receiver cannot stall
module int8_kronecker_product_core import int8kp_pkg::*; #(
  parameter int LeftCapacity  = LEFT_CAPACITY_DEF,
  parameter int RightCapacity = RIGHT_CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic [IDX_W-1:0]         elem_index_i,
  input  logic signed [VAL_W-1:0]  elem_value_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DIM_W-1:0]         cfg_data_i,
  output logic                     result_valid_o,
  output logic signed [VAL_W-1:0]  product_o,
  output logic                     last_product_o,
  output logic                     size_error_o
);

  cfg_t  cfg_q, cfg_d;
  logic  push, pop, q_valid;
  qent_t push_data, q_head;
  logic [$clog2(QUEUE_DEPTH):0] q_count;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROWS_A: cfg_d.rows_a = cfg_data_i;
        CFG_COLS_A: cfg_d.cols_a = cfg_data_i;
        CFG_ROWS_B: cfg_d.rows_b = cfg_data_i;
        CFG_COLS_B: cfg_d.cols_b = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_a <= DIM_W'(1);
      cfg_q.cols_a <= DIM_W'(1);
      cfg_q.rows_b <= DIM_W'(1);
      cfg_q.cols_b <= DIM_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  int8kp_front #(
    .LeftCapacity  (LeftCapacity),
    .RightCapacity (RightCapacity)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_type_i   (req_type_i),
    .elem_index_i (elem_index_i),
    .elem_value_i (elem_value_i),
    .cfg_i        (cfg_q),
    .q_count_i    (q_count),
    .busy_o       (busy_o),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  int8kp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .count_o     (q_count)
  );

  int8kp_back #(
    .LeftCapacity  (LeftCapacity),
    .RightCapacity (RightCapacity)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_head_i       (q_head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .product_o      (product_o),
    .last_product_o (last_product_o),
    .size_error_o   (size_error_o)
  );

endmodule

FILE: tb/tb_int8_kronecker_product_core.sv
// self-checking testbench for int8_kronecker_product_core: loads, runs, config changes
// predicts each product transaction from its own copy of the stores and matrix sizes
// depends on int8kp_pkg and the core rtl
module tb_int8_kronecker_product_core import int8kp_pkg::*;;

  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 40;
  localparam int ClkHalf       = 4;

  typedef struct {
    logic signed [VAL_W-1:0] product;
    logic                    last;
    logic                    err;
  } kron_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [REQ_W-1:0]        req_type_i;
  logic [IDX_W-1:0]        elem_index_i;
  logic signed [VAL_W-1:0] elem_value_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [DIM_W-1:0]        cfg_data_i;
  logic                    result_valid_o;
  logic signed [VAL_W-1:0] product_o;
  logic                    last_product_o;
  logic                    size_error_o;

  logic signed [VAL_W-1:0] left_elems  [LEFT_CAPACITY_DEF];
  logic signed [VAL_W-1:0] right_elems [RIGHT_CAPACITY_DEF];
  logic [DIM_W-1:0]        dim_rows_a, dim_cols_a, dim_rows_b, dim_cols_b;

  kron_result_t kron_expected_q [$];
  kron_result_t kron_head;
  int           mismatch_count;
  int           quiet_cycles;
  int           sender_idle_pct;

  int8_kronecker_product_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .elem_index_i   (elem_index_i),
    .elem_value_i   (elem_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .product_o      (product_o),
    .last_product_o (last_product_o),
    .size_error_o   (size_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void predict_kron_products();
    int           size_a;
    int           size_b;
    int           a_val;
    int           b_val;
    int           prod;
    kron_result_t res;
    size_a = dim_rows_a * dim_cols_a;
    size_b = dim_rows_b * dim_cols_b;
    if (size_a > LEFT_CAPACITY_DEF || size_b > RIGHT_CAPACITY_DEF ||
        size_a * size_b > MAX_PRODUCTS) begin
      res.product = '0;
      res.last    = 1'b1;
      res.err     = 1'b1;
      kron_expected_q.push_back(res);
      return;
    end
    if (size_a == 0 || size_b == 0) return;
    for (int ca = 0; ca < dim_cols_a; ca++) begin
      for (int cb = 0; cb < dim_cols_b; cb++) begin
        for (int ra = 0; ra < dim_rows_a; ra++) begin
          a_val = left_elems[ca * dim_rows_a + ra];
          for (int rb = 0; rb < dim_rows_b; rb++) begin
            b_val       = right_elems[cb * dim_rows_b + rb];
            prod        = a_val * b_val;
            res.product = prod[VAL_W-1:0];
            res.last    = 1'b0;
            res.err     = 1'b0;
            kron_expected_q.push_back(res);
          end
        end
      end
    end
    kron_expected_q[$].last = 1'b1;
  endfunction

  function automatic void apply_request(input logic [REQ_W-1:0] req,
                                        input logic [IDX_W-1:0] idx,
                                        input logic signed [VAL_W-1:0] val);
    case (req)
      REQ_WR_A: if (idx < LEFT_CAPACITY_DEF) left_elems[idx] = val;
      REQ_WR_B: if (idx < RIGHT_CAPACITY_DEF) right_elems[idx] = val;
      REQ_RUN:  predict_kron_products();
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    start_i      = 1'b1;
    req_type_i   = req;
    elem_index_i = idx;
    elem_value_i = val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_request(req, idx, val);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_ROWS_A: dim_rows_a = data;
      CFG_COLS_A: dim_cols_a = data;
      CFG_ROWS_B: dim_rows_b = data;
      CFG_COLS_B: dim_cols_b = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (kron_expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_dims(input int ra, input int ca, input int rb, input int cb);
    drain_results();
    write_reg(CFG_ROWS_A, ra[DIM_W-1:0]);
    write_reg(CFG_COLS_A, ca[DIM_W-1:0]);
    write_reg(CFG_ROWS_B, rb[DIM_W-1:0]);
    write_reg(CFG_COLS_B, cb[DIM_W-1:0]);
  endtask

  task automatic pick_random_dims();
    int ra, ca, rb, cb;
    if ($urandom_range(7) == 0) begin
      ra = $urandom_range(15);
      ca = $urandom_range(15);
      rb = $urandom_range(15);
      cb = $urandom_range(15);
    end else begin
      ra = $urandom_range(1, 8);
      ca = $urandom_range(1, 8 / ra);
      rb = $urandom_range(1, 8);
      cb = $urandom_range(1, 8 / rb);
    end
    set_dims(ra, ca, rb, cb);
  endtask

  task automatic test_fill_stores();
    logic signed [VAL_W-1:0] a_vals [8];
    logic signed [VAL_W-1:0] b_vals [8];
    a_vals = '{-8'sd128, 8'sd127, 8'sd0, -8'sd1, 8'sd1, 8'sd64, -8'sd64, 8'sd85};
    b_vals = '{8'sd127, -8'sd128, -8'sd1, 8'sd0, -8'sd86, 8'sd2, -8'sd2, 8'sd1};
    for (int i = 0; i < 8; i++) send_request(REQ_WR_A, i[IDX_W-1:0], a_vals[i]);
    for (int i = 0; i < 8; i++) send_request(REQ_WR_B, i[IDX_W-1:0], b_vals[i]);
  endtask

  task automatic test_run_default();
    send_request(REQ_RUN, '0, '0);
  endtask

  task automatic test_largest_product();
    set_dims(8, 1, 1, 8);
    send_request(REQ_RUN, 3'd5, 8'sd17);
    set_dims(1, 8, 8, 1);
    send_request(REQ_RUN, 3'd2, -8'sd5);
  endtask

  task automatic test_size_error();
    set_dims(15, 15, 1, 1);
    send_request(REQ_RUN, 3'd7, 8'sd127);
    set_dims(1, 1, 3, 3);
    send_request(REQ_RUN, '0, -8'sd128);
  endtask

  task automatic test_empty_matrix();
    set_dims(0, 4, 2, 2);
    send_request(REQ_RUN, '0, '0);
    set_dims(2, 2, 2, 0);
    send_request(REQ_RUN, '0, '0);
  endtask

  task automatic test_unused_request();
    set_dims(2, 4, 4, 2);
    send_request(REQ_NONE, 3'd7, -8'sd1);
    send_request(REQ_RUN, 3'd1, 8'sd42);
  endtask

  task automatic test_random(input int n_items, input int idle_pct);
    int                 sent;
    int                 pick;
    logic [REQ_W-1:0]   req;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 25 == 0) pick_random_dims();
      pick = $urandom_range(99);
      if (pick < 40) req = REQ_WR_A;
      else if (pick < 80) req = REQ_WR_B;
      else if (pick < 96) req = REQ_RUN;
      else req = REQ_NONE;
      send_request(req, IDX_W'($urandom), VAL_W'($urandom));
      if (req != REQ_NONE) sent++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (kron_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction product %0d last %0b err %0b",
                                  product_o, last_product_o, size_error_o));
      end else begin
        kron_head = kron_expected_q.pop_front();
        if (product_o !== kron_head.product || last_product_o !== kron_head.last ||
            size_error_o !== kron_head.err) begin
          report_mismatch($sformatf("got product %0d last %0b err %0b, want %0d %0b %0b",
                                    product_o, last_product_o, size_error_o,
                                    kron_head.product, kron_head.last, kron_head.err));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || (cfg_valid_i && cfg_ready_o) || result_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_int8_kronecker_product_core: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    req_type_i      = REQ_NONE;
    elem_index_i    = '0;
    elem_value_i    = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_ROWS_A;
    cfg_data_i      = '0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    sender_idle_pct = 0;
    dim_rows_a      = 4'd1;
    dim_cols_a      = 4'd1;
    dim_rows_b      = 4'd1;
    dim_cols_b      = 4'd1;
    foreach (left_elems[i]) left_elems[i] = '0;
    foreach (right_elems[i]) right_elems[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_stores();
    test_run_default();
    test_largest_product();
    test_size_error();
    test_empty_matrix();
    test_unused_request();
    test_random(75, 0);
    test_random(75, 83);
    test_random(75, 0);
    test_random(75, 7);
    drain_results();

    if (mismatch_count == 0) begin
      $display("tb_int8_kronecker_product_core: done, clean");
    end else begin
      $display("tb_int8_kronecker_product_core: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/int8kp_pkg.sv
design/int8kp_front.sv
design/int8kp_fifo.sv
design/int8kp_back.sv
design/int8_kronecker_product_core.sv
tb/tb_int8_kronecker_product_core.sv
